/* hdl/msort_pkg.sv */
// msort_pkg: shared types and constants for the stable merge sorter
// holds the data width and the start/status structs between sequencer and top
// no dependencies
package msort_pkg;

    localparam int DATA_W = 32;

    typedef struct packed {
        logic start;
    } msort_ctl_t;

    typedef struct packed {
        logic done;
        logic bank;
    } msort_sts_t;

endpackage

/* hdl/stable_merge_sorter_unit.sv */
// Stable merge sorter. Values are loaded one per cycle into a 32-bit ram until a
// transfer with last_in set; up to MAX_ITEMS values are kept and later ones are
// dropped, which raises overflow on every result of that set. The set is then
// sorted ascending (signed, equal keys keep their arrival order) by bottom-up
// merge passes that ping-pong between two rams with one read port each. A pass
// sets up each run pair and reads the run heads, then writes one merged element
// and reads the next one from that run while it has one; there are ceil(log2(n))
// passes. Each result is then read from the ram and shown until it is taken, and
// the next read starts only after that. No input is taken while a set is being
// sorted or drained.
// depends on msort_pkg, msort_ram, msort_merge
module stable_merge_sorter_unit #(
    parameter int MAX_ITEMS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] value_in,
    input  logic               last_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] value_out,
    output logic               last_out,
    output logic               overflow
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int DW = msort_pkg::DATA_W;

    typedef enum logic [1:0] {
        T_LOAD,
        T_SORT,
        T_RD,
        T_SHOW
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] k_reg, k_next;

    msort_pkg::msort_ctl_t m_ctl;
    msort_pkg::msort_sts_t m_sts;

    logic          in_xfer;
    logic          out_xfer;
    logic          load_we;
    logic          m_rd_en;
    logic [AW-1:0] m_rd_addr;
    logic          m_wr_en;
    logic [AW-1:0] m_wr_addr;
    logic [DW-1:0] m_wr_data;
    logic [DW-1:0] rdata0;
    logic [DW-1:0] rdata1;
    logic [DW-1:0] rdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic          we0;
    logic          we1;
    logic [AW-1:0] waddr0;
    logic [DW-1:0] wdata0;

    assign in_ready  = (state_reg == T_LOAD);
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = (state_reg == T_SHOW);
    assign out_xfer  = out_valid && out_ready;
    assign load_we   = in_xfer && (count_reg < CW'(MAX_ITEMS));

    assign rdata     = m_sts.bank ? rdata1 : rdata0;
    assign value_out = rdata;
    assign last_out  = ((k_reg + CW'(1)) == count_reg);
    assign overflow  = ovf_reg;

    assign ram_re    = (state_reg == T_SORT) ? m_rd_en : (state_reg == T_RD);
    assign ram_raddr = (state_reg == T_SORT) ? m_rd_addr : k_reg[AW-1:0];
    assign we0       = load_we || (m_wr_en && m_sts.bank);
    assign we1       = m_wr_en && !m_sts.bank;
    assign waddr0    = load_we ? count_reg[AW-1:0] : m_wr_addr;
    assign wdata0    = load_we ? value_in : m_wr_data;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        k_next      = k_reg;
        m_ctl.start = 1'b0;

        unique case (state_reg)
            T_LOAD:
            begin
                if (in_xfer)
                begin
                    if (load_we)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_in)
                    begin
                        m_ctl.start = 1'b1;
                        state_next  = T_SORT;
                    end
                end
            end
            T_SORT:
            begin
                if (m_sts.done)
                begin
                    k_next     = '0;
                    state_next = T_RD;
                end
            end
            T_RD:
            begin
                state_next = T_SHOW;
            end
            T_SHOW:
            begin
                if (out_xfer)
                begin
                    if (last_out)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = T_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + CW'(1);
                        state_next = T_RD;
                    end
                end
            end
            default:
            begin
                state_next = T_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            k_reg     <= k_next;
        end
    end

    msort_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_ITEMS)
    ) u_ram0 (
        .clk   (clk),
        .we    (we0),
        .waddr (waddr0),
        .wdata (wdata0),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rdata0)
    );

    msort_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_ITEMS)
    ) u_ram1 (
        .clk   (clk),
        .we    (we1),
        .waddr (m_wr_addr),
        .wdata (m_wr_data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rdata1)
    );

    msort_merge #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (m_ctl),
        .n       (count_next),
        .rdata   (rdata),
        .rd_en   (m_rd_en),
        .rd_addr (m_rd_addr),
        .wr_en   (m_wr_en),
        .wr_addr (m_wr_addr),
        .wr_data (m_wr_data),
        .sts     (m_sts)
    );

    a_no_merge_write_in_load: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_ready |-> !m_wr_en
    ) else $error("merge write while loading");

    a_ovf_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (count_reg == CW'(MAX_ITEMS))
    ) else $error("overflow flagged before the buffer was full");

    a_closed_after_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_xfer && last_in) |=> (!in_ready && (count_reg != '0))
    ) else $error("input still open or empty set after last transfer");

    a_done_only_sorting: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_sts.done |-> (state_reg == T_SORT)
    ) else $error("sort completion outside the sort phase");

endmodule

/* hdl/msort_ram.sv */
// msort_ram: generic single-write, single-read synchronous ram
// read data registered, holds when read is not enabled
// no dependencies
module msort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/msort_merge.sv */
// msort_merge: bottom-up merge pass sequencer over two ping-pong rams
// reads the source bank one element at a time, writes the merged run to the other
// depends on msort_pkg
module msort_merge #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  msort_pkg::msort_ctl_t                ctl,
    input  logic [$clog2(MAX_ITEMS+1)-1:0]       n,
    input  logic [msort_pkg::DATA_W-1:0]         rdata,
    output logic                                 rd_en,
    output logic [$clog2(MAX_ITEMS)-1:0]         rd_addr,
    output logic                                 wr_en,
    output logic [$clog2(MAX_ITEMS)-1:0]         wr_addr,
    output logic [msort_pkg::DATA_W-1:0]         wr_data,
    output msort_pkg::msort_sts_t                sts
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int SW = CW + 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PASS,
        ST_SEG,
        ST_RD_A,
        ST_RD_B,
        ST_MERGE,
        ST_FILL_A,
        ST_FILL_B
    } state_t;

    state_t                      state_reg, state_next;
    logic                        bank_reg, bank_next;
    logic                        done_reg, done_next;
    logic [CW:0]                 width_reg, width_next;
    logic [CW-1:0]               n_reg, n_next;
    logic [CW-1:0]               lo_reg, lo_next;
    logic [CW-1:0]               a_reg, a_next;
    logic [CW-1:0]               b_reg, b_next;
    logic [CW-1:0]               o_reg, o_next;
    logic [CW-1:0]               mid_reg, mid_next;
    logic [CW-1:0]               hi_reg, hi_next;
    logic [msort_pkg::DATA_W-1:0] a_val_reg, a_val_next;
    logic [msort_pkg::DATA_W-1:0] b_val_reg, b_val_next;

    logic [SW-1:0] mid_sum;
    logic [SW-1:0] hi_sum;
    logic [SW-1:0] n_ext;
    logic [CW-1:0] a_inc;
    logic [CW-1:0] b_inc;
    logic          a_ok;
    logic          b_ok;
    logic          take_a;
    logic          seg_done;

    always_comb
    begin
        n_ext   = SW'(n_reg);
        mid_sum = SW'(lo_reg) + SW'(width_reg);
        hi_sum  = SW'(lo_reg) + (SW'(width_reg) << 1);
        a_inc   = a_reg + CW'(1);
        b_inc   = b_reg + CW'(1);
        a_ok    = (a_reg < mid_reg);
        b_ok    = (b_reg < hi_reg);
        take_a  = a_ok && (!b_ok || ($signed(a_val_reg) <= $signed(b_val_reg)));

        state_next = state_reg;
        bank_next  = bank_reg;
        done_next  = 1'b0;
        width_next = width_reg;
        n_next     = n_reg;
        lo_next    = lo_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        o_next     = o_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        a_val_next = a_val_reg;
        b_val_next = b_val_reg;
        rd_addr    = a_reg[AW-1:0];
        wr_en      = 1'b0;
        seg_done   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctl.start)
                begin
                    n_next     = n;
                    width_next = (CW+1)'(1);
                    bank_next  = 1'b0;
                    state_next = ST_PASS;
                end
            end
            ST_PASS:
            begin
                if (width_reg >= (CW+1)'(n_reg))
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    lo_next    = '0;
                    state_next = ST_SEG;
                end
            end
            ST_SEG:
            begin
                mid_next   = (mid_sum > n_ext) ? n_reg : mid_sum[CW-1:0];
                hi_next    = (hi_sum > n_ext) ? n_reg : hi_sum[CW-1:0];
                a_next     = lo_reg;
                b_next     = (mid_sum > n_ext) ? n_reg : mid_sum[CW-1:0];
                o_next     = lo_reg;
                rd_addr    = lo_reg[AW-1:0];
                state_next = ST_RD_A;
            end
            ST_RD_A:
            begin
                a_val_next = rdata;
                rd_addr    = b_reg[AW-1:0];
                state_next = b_ok ? ST_RD_B : ST_MERGE;
            end
            ST_RD_B:
            begin
                b_val_next = rdata;
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                wr_en  = 1'b1;
                o_next = o_reg + CW'(1);
                if (take_a)
                begin
                    a_next  = a_inc;
                    rd_addr = a_inc[AW-1:0];
                    if (a_inc < mid_reg)
                    begin
                        state_next = ST_FILL_A;
                    end
                    else if (!b_ok)
                    begin
                        seg_done = 1'b1;
                    end
                end
                else
                begin
                    b_next  = b_inc;
                    rd_addr = b_inc[AW-1:0];
                    if (b_inc < hi_reg)
                    begin
                        state_next = ST_FILL_B;
                    end
                    else if (!a_ok)
                    begin
                        seg_done = 1'b1;
                    end
                end
            end
            ST_FILL_A:
            begin
                a_val_next = rdata;
                state_next = ST_MERGE;
            end
            ST_FILL_B:
            begin
                b_val_next = rdata;
                state_next = ST_MERGE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (seg_done)
        begin
            if (hi_sum >= n_ext)
            begin
                width_next = width_reg << 1;
                bank_next  = !bank_reg;
                state_next = ST_PASS;
            end
            else
            begin
                lo_next    = hi_sum[CW-1:0];
                state_next = ST_SEG;
            end
        end
    end

    assign rd_en    = (state_reg != ST_IDLE);
    assign wr_addr  = o_reg[AW-1:0];
    assign wr_data  = take_a ? a_val_reg : b_val_reg;
    assign sts.done = done_reg;
    assign sts.bank = bank_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bank_reg  <= 1'b0;
            done_reg  <= 1'b0;
            width_reg <= '0;
            n_reg     <= '0;
            lo_reg    <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            o_reg     <= '0;
            mid_reg   <= '0;
            hi_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bank_reg  <= bank_next;
            done_reg  <= done_next;
            width_reg <= width_next;
            n_reg     <= n_next;
            lo_reg    <= lo_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            o_reg     <= o_next;
            mid_reg   <= mid_next;
            hi_reg    <= hi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_val_reg <= a_val_next;
        b_val_reg <= b_val_next;
    end

endmodule

/* bench/stable_merge_sorter_unit_test.sv */
// stable_merge_sorter_unit_test: self-checking bench for the stable merge sorter
// loads signed sets with random gaps and stalls, predicts the sorted output per set
// depends on msort_pkg and stable_merge_sorter_unit
`timescale 1ns / 100ps

module stable_merge_sorter_unit_test;

    localparam int CAPACITY    = 64;
    localparam int TAIL_ITEMS  = 40;
    localparam int DRAIN_WAIT  = 64;
    localparam int CYCLE_LIMIT = 500000;

    typedef logic signed [msort_pkg::DATA_W-1:0] word_t;

    typedef struct packed {
        word_t value;
        logic  last;
        logic  hold;
    } load_item_t;

    typedef struct packed {
        word_t value;
        logic  last;
        logic  ovf;
    } sorted_result_t;

    logic  clk;
    logic  rst_n;
    logic  in_valid  = 1'b0;
    logic  in_ready;
    word_t value_in  = '0;
    logic  last_in   = 1'b0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    word_t value_out;
    logic  last_out;
    logic  overflow;

    load_item_t     pending_q[$];
    sorted_result_t sorted_expect_q[$];
    word_t          set_values[$];
    logic           set_overflow = 1'b0;
    load_item_t     next_item;
    sorted_result_t want;
    int             send_gap    = 0;
    int             recv_stall  = 0;
    int             cycle_count = 0;
    int             fail_count  = 0;
    int             item_total  = 0;

    stable_merge_sorter_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value_in  (value_in),
        .last_in   (last_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value_out (value_out),
        .last_out  (last_out),
        .overflow  (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // store one value of the open set; on last, sort stably and queue the results
    task automatic load_value(input word_t v, input logic is_last);
        word_t          run[$];
        word_t          key;
        sorted_result_t res;
        int             i;
        int             j;
        if (set_values.size() < CAPACITY)
            set_values.push_back(v);
        else
            set_overflow = 1'b1;
        if (is_last)
        begin
            run = set_values;
            // insertion sort, strict compare keeps arrival order on ties
            for (i = 1; i < run.size(); i++)
            begin
                key = run[i];
                j = i - 1;
                while (j >= 0 && run[j] > key)
                begin
                    run[j + 1] = run[j];
                    j--;
                end
                run[j + 1] = key;
            end
            for (i = 0; i < run.size(); i++)
            begin
                res.value = run[i];
                res.last  = (i == run.size() - 1);
                res.ovf   = set_overflow;
                sorted_expect_q.push_back(res);
            end
            set_values.delete();
            set_overflow = 1'b0;
        end
    endtask

    function automatic logic idle_allowed();
        return (pending_q.size() >= TAIL_ITEMS) && ((cycle_count % 256) < 192);
    endfunction

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            value_in <= '0;
            last_in  <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                load_value(value_in, last_in);
            if (!(in_valid && !in_ready))
            begin
                if (send_gap > 0)
                begin
                    send_gap = send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() > 0 &&
                         !(pending_q[0].hold && sorted_expect_q.size() > 0))
                begin
                    next_item = pending_q.pop_front();
                    in_valid <= 1'b1;
                    value_in <= next_item.value;
                    last_in  <= next_item.last;
                    if (idle_allowed() && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 14);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (recv_stall > 0)
        begin
            recv_stall = recv_stall - 1;
            out_ready <= 1'b0;
        end
        else if (idle_allowed() && $urandom_range(0, 4) == 0)
        begin
            recv_stall = $urandom_range(1, 14) - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (sorted_expect_q.size() == 0)
            begin
                $error("unexpected result transfer: value_out %0d", value_out);
                fail_count++;
            end
            else
            begin
                want = sorted_expect_q.pop_front();
                if (value_out !== want.value)
                begin
                    $error("value_out expected %0d actual %0d", want.value, value_out);
                    fail_count++;
                end
                if (last_out !== want.last)
                begin
                    $error("last_out expected %0b actual %0b", want.last, last_out);
                    fail_count++;
                end
                if (overflow !== want.ovf)
                begin
                    $error("overflow expected %0b actual %0b", want.ovf, overflow);
                    fail_count++;
                end
            end
        end
    end

    task automatic queue_item(input word_t v, input logic is_last, input logic hold);
        load_item_t it;
        it.value = v;
        it.last  = is_last;
        it.hold  = hold;
        pending_q.push_back(it);
        item_total++;
    endtask

    function automatic word_t rand_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2, 3, 4: return $signed($urandom_range(0, 8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_set(input int size, input logic hold);
        int k;
        for (k = 0; k < size; k++)
            queue_item(rand_value(), k == size - 1, hold && k == 0);
    endtask

    initial
    begin
        int size;
        int pick;

        // single-element set at the negative extreme
        queue_item(32'sh8000_0000, 1'b1, 1'b0);
        // extremes mixed
        queue_item(32'sh7fff_ffff, 1'b0, 1'b0);
        queue_item(32'sh8000_0000, 1'b0, 1'b0);
        queue_item(32'sd0, 1'b0, 1'b0);
        queue_item(-32'sd1, 1'b0, 1'b0);
        queue_item(32'sd1, 1'b1, 1'b0);
        // equal keys
        queue_item(32'sd5, 1'b0, 1'b0);
        queue_item(-32'sd3, 1'b0, 1'b0);
        queue_item(32'sd5, 1'b0, 1'b0);
        queue_item(32'sd5, 1'b0, 1'b0);
        queue_item(-32'sd3, 1'b1, 1'b0);
        // descending run
        for (int v = 3; v >= -3; v--)
            queue_item(v, v == -3, 1'b0);
        // ascending pair
        queue_item(-32'sd7, 1'b0, 1'b0);
        queue_item(32'sd7, 1'b1, 1'b0);

        // full set, then a set three beyond capacity, each after the pipe drains
        queue_set(CAPACITY, 1'b1);
        queue_set(CAPACITY + 3, 1'b1);

        while (item_total < 350)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                size = $urandom_range(CAPACITY + 1, CAPACITY + 8);
            else if (pick < 3)
                size = $urandom_range(17, CAPACITY);
            else
                size = $urandom_range(1, 16);
            queue_set(size, $urandom_range(0, 15) == 0);
        end

        @(posedge clk);
        while (pending_q.size() > 0 || in_valid || sorted_expect_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
